/* rtl/crp_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths and register codes of the row panel packing address generator
package crp_pkg;

  localparam int BlockRowsDef = 8;
  localparam int BlockRowsMax = 64;

  localparam int DimW    = 13;
  localparam int PanelW  = 14;
  localparam int RowIdxW = 14;
  localparam int BaseW   = 20;
  localparam int ColOffW = DimW + $clog2(BlockRowsMax) + 1;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  typedef enum logic {
    OpStart = 1'b0,
    OpStep  = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegRows        = 3'd0,
    RegCols        = 3'd1,
    RegInputHeight = 3'd2,
    RegStride      = 3'd3,
    RegDilation    = 3'd4,
    RegPadding     = 3'd5,
    RegRowPitch    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [12:0] rows;
    logic [12:0] cols;
    logic [12:0] input_height;
    logic [4:0]  stride;
    logic [4:0]  dilation;
    logic [3:0]  padding;
    logic [15:0] row_pitch;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic [11:0] start_row;
    logic [3:0]  kernel_row;
  } in_item_t;

  typedef struct packed {
    logic [23:0] dest_index;
    logic [27:0] source_address;
    logic        zero_fill;
    logic        last;
    logic        exhausted;
  } out_item_t;

  // one classified step, handed from the front to the back
  typedef struct packed {
    logic                      exhausted;
    logic                      last;
    logic [PanelW-1:0]         panel_start;
    logic [ColOffW-1:0]        col_off;
    logic [DimW-1:0]           column;
    logic [RowIdxW-1:0]        row_idx;
    logic signed [BaseW-1:0]   base_row;
  } step_t;

endpackage

/* rtl/crp_fifo.sv */
`timescale 1ns / 1ps
// small register queue with full/empty flags
module crp_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  T     wr_data,
  input  logic pop,
  output logic empty,
  output T     rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T              mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/crp_front.sv */
`timescale 1ns / 1ps
// front end: takes start and step items, keeps the job counters, emits step descriptors
module crp_front #(
  parameter int BLOCK_ROWS = crp_pkg::BlockRowsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  crp_pkg::cfg_t     cfg,
  input  logic              in_push,
  output logic              in_full,
  input  crp_pkg::in_item_t in_item,
  output logic              q_push,
  input  logic              q_full,
  output crp_pkg::step_t    q_desc
);
  import crp_pkg::*;

  localparam int RipW = $clog2(BLOCK_ROWS + 1);

  logic                    active_r, active_nxt;
  logic [PanelW-1:0]       ps_r, ps_nxt;
  logic [DimW-1:0]         col_r, col_nxt;
  logic [RipW-1:0]         rip_r, rip_nxt;
  logic signed [BaseW-1:0] base_r, base_nxt;

  logic                accept;
  logic [PanelW-1:0]   span;
  logic [PanelW-1:0]   rr;
  logic [RipW-1:0]     rip_inc;
  logic [PanelW-1:0]   col_inc;
  logic [PanelW:0]     ps_inc;
  logic                wrap_row, wrap_col, done;
  logic [BaseW-1:0]    base_calc;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && (in_item.operation == OpStep);

  always_comb begin
    span = PanelW'(cfg.rows) - ps_r;
    // rows left in this panel, at least one even when rows has shrunk below panel_start
    if (PanelW'(cfg.rows) > ps_r) begin
      rr = (span < PanelW'(BLOCK_ROWS)) ? span : PanelW'(BLOCK_ROWS);
    end else begin
      rr = PanelW'(1);
    end
    rip_inc  = rip_r + RipW'(1);
    col_inc  = PanelW'(col_r) + PanelW'(1);
    ps_inc   = (PanelW+1)'(ps_r) + (PanelW+1)'(BLOCK_ROWS);
    wrap_row = (PanelW'(rip_inc) >= rr);
    wrap_col = (col_inc >= PanelW'(cfg.cols));
    done     = (ps_inc >= (PanelW+1)'(cfg.rows));

    base_calc = BaseW'(BaseW'(cfg.stride) * BaseW'(in_item.start_row))
              + BaseW'(BaseW'(cfg.dilation) * BaseW'(in_item.kernel_row))
              - BaseW'(cfg.padding);

    q_desc.exhausted   = !active_r;
    q_desc.last        = active_r && wrap_row && wrap_col && done;
    q_desc.panel_start = ps_r;
    q_desc.col_off     = ColOffW'(col_r) * ColOffW'(BLOCK_ROWS) + ColOffW'(rip_r);
    q_desc.column      = col_r;
    q_desc.row_idx     = RowIdxW'(ps_r) + RowIdxW'(rip_r);
    q_desc.base_row    = base_r;
  end

  always_comb begin
    active_nxt = active_r;
    ps_nxt     = ps_r;
    col_nxt    = col_r;
    rip_nxt    = rip_r;
    base_nxt   = base_r;
    if (accept) begin
      if (in_item.operation == OpStart) begin
        base_nxt   = $signed(base_calc);
        ps_nxt     = '0;
        col_nxt    = '0;
        rip_nxt    = '0;
        active_nxt = (cfg.rows != '0) && (cfg.cols != '0);
      end else if (active_r) begin
        if (wrap_row) begin
          rip_nxt = '0;
          if (wrap_col) begin
            col_nxt = '0;
            if (done) begin
              ps_nxt     = '0;
              active_nxt = 1'b0;
            end else begin
              ps_nxt = ps_inc[PanelW-1:0];
            end
          end else begin
            col_nxt = col_inc[DimW-1:0];
          end
        end else begin
          rip_nxt = rip_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ps_r     <= '0;
      col_r    <= '0;
      rip_r    <= '0;
      base_r   <= '0;
    end else begin
      active_r <= active_nxt;
      ps_r     <= ps_nxt;
      col_r    <= col_nxt;
      rip_r    <= rip_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule

/* rtl/crp_back.sv */
`timescale 1ns / 1ps
// back end: three stage address pipeline from step descriptor to result item
module crp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  crp_pkg::cfg_t      cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  crp_pkg::step_t     q_desc,
  output logic               o_push,
  input  logic               o_full,
  output crp_pkg::out_item_t o_item
);
  import crp_pkg::*;

  localparam int ProdW = PanelW + DimW;
  localparam int SrowW = 5 + RowIdxW;
  localparam int YW    = BaseW + 1;

  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  // stage 1: panel offset and row step products
  logic [ProdW-1:0]        s1_pprod_r;
  logic [SrowW-1:0]        s1_srow_r;
  logic [ColOffW-1:0]      s1_coloff_r;
  logic [DimW-1:0]         s1_col_r;
  logic signed [BaseW-1:0] s1_base_r;
  logic                    s1_last_r, s1_exh_r;

  // stage 2: destination index, source row and bounds check
  logic [23:0]     s2_dest_r;
  logic [DimW-1:0] s2_y_r;
  logic            s2_zero_r;
  logic [DimW-1:0] s2_col_r;
  logic            s2_last_r, s2_exh_r;

  // stage 3: row times pitch
  logic [28:0]     s3_prod_r;
  logic [23:0]     s3_dest_r;
  logic            s3_zero_r;
  logic [DimW-1:0] s3_col_r;
  logic            s3_last_r, s3_exh_r;

  logic signed [YW-1:0] y;
  logic                 zero;
  logic [28:0]          src_sum;

  assign en3    = !v3_r || !o_full;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign q_pop  = !q_empty && en1;
  assign o_push = v3_r && !o_full;

  always_comb begin
    y    = $signed({s1_base_r[BaseW-1], s1_base_r}) + $signed({2'b00, s1_srow_r});
    zero = y[YW-1] || (y >= $signed({{(YW-DimW){1'b0}}, cfg.input_height}));
    src_sum = s3_prod_r + 29'(s3_col_r);

    o_item.exhausted      = s3_exh_r;
    o_item.dest_index     = s3_exh_r ? '0 : s3_dest_r;
    o_item.zero_fill      = !s3_exh_r && s3_zero_r;
    o_item.last           = !s3_exh_r && s3_last_r;
    o_item.source_address = (s3_exh_r || s3_zero_r) ? '0 : src_sum[27:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= !q_empty;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pprod_r  <= ProdW'(q_desc.panel_start) * ProdW'(cfg.cols);
      s1_srow_r   <= SrowW'(cfg.stride) * SrowW'(q_desc.row_idx);
      s1_coloff_r <= q_desc.col_off;
      s1_col_r    <= q_desc.column;
      s1_base_r   <= q_desc.base_row;
      s1_last_r   <= q_desc.last;
      s1_exh_r    <= q_desc.exhausted;
    end
    if (en2) begin
      s2_dest_r <= 24'(s1_pprod_r + ProdW'(s1_coloff_r));
      s2_y_r    <= y[DimW-1:0];
      s2_zero_r <= zero;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
      s2_exh_r  <= s1_exh_r;
    end
    if (en3) begin
      s3_prod_r <= 29'(s2_y_r) * 29'(cfg.row_pitch);
      s3_dest_r <= s2_dest_r;
      s3_zero_r <= s2_zero_r;
      s3_col_r  <= s2_col_r;
      s3_last_r <= s2_last_r;
      s3_exh_r  <= s2_exh_r;
    end
  end

endmodule

/* rtl/conv_row_panel_pack_addrgen.sv */
`timescale 1ns / 1ps
// Row panel packing address generator, top level: config registers, front, queues, back.
// A step item passes the step queue, back end stages s1 to s3 and the result queue to out_item.
// Throughput: one item per cycle while no queue is full; the three stage multiply pipeline
// in the back end sets it. A start item produces no result and is absorbed in the front end.
// Reset (rst_n low, synchronous) drops any job, empties both queues and loads the
// register reset values: rows, cols, input_height, stride, dilation, row_pitch 1, padding 0.
module conv_row_panel_pack_addrgen #(
  parameter int BLOCK_ROWS = crp_pkg::BlockRowsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  crp_pkg::in_item_t            in_item,
  output logic                         out_empty,
  input  logic                         out_pop,
  output crp_pkg::out_item_t           out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [crp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [crp_pkg::CfgDataW-1:0] cfg_data
);
  import crp_pkg::*;

  localparam int QueueDepth = 2;

  cfg_t      cfg_r;
  logic      q_push, q_full, q_pop, q_empty;
  step_t     q_wr, q_rd;
  logic      o_push, o_full;
  out_item_t o_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows         <= 13'd1;
      cfg_r.cols         <= 13'd1;
      cfg_r.input_height <= 13'd1;
      cfg_r.stride       <= 5'd1;
      cfg_r.dilation     <= 5'd1;
      cfg_r.padding      <= 4'd0;
      cfg_r.row_pitch    <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegRows:        cfg_r.rows         <= cfg_data[12:0];
        RegCols:        cfg_r.cols         <= cfg_data[12:0];
        RegInputHeight: cfg_r.input_height <= cfg_data[12:0];
        RegStride:      cfg_r.stride       <= cfg_data[4:0];
        RegDilation:    cfg_r.dilation     <= cfg_data[4:0];
        RegPadding:     cfg_r.padding      <= cfg_data[3:0];
        RegRowPitch:    cfg_r.row_pitch    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  crp_front #(
    .BLOCK_ROWS(BLOCK_ROWS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_desc  (q_wr)
  );

  crp_fifo #(
    .T     (step_t),
    .Depth (QueueDepth)
  ) u_step_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  crp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_desc  (q_rd),
    .o_push  (o_push),
    .o_full  (o_full),
    .o_item  (o_item)
  );

  crp_fifo #(
    .T     (out_item_t),
    .Depth (QueueDepth)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (o_push),
    .full    (o_full),
    .wr_data (o_item),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (out_item)
  );

endmodule

/* rtl/crp_checker.sv */
`timescale 1ns / 1ps
// port level checks on the packing address generator, bound to the top level
module crp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input crp_pkg::out_item_t out_item
);
  import crp_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // an exhausted answer carries nothing else
  a_exh_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.exhausted) |->
      (out_item.dest_index == '0) && (out_item.source_address == '0) &&
      !out_item.zero_fill && !out_item.last)
    else $error("exhausted item with nonzero fields");

  // padding rows never carry a source address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.zero_fill) |-> (out_item.source_address == '0))
    else $error("zero fill item with source address");

  // a waiting item holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("pending item changed or vanished");

endmodule

bind conv_row_panel_pack_addrgen crp_checker u_crp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

/* tb/tb_conv_row_panel_pack_addrgen.sv */
`timescale 1ns / 1ps
// self-checking testbench for the row panel packing address generator
module tb_conv_row_panel_pack_addrgen;
  import crp_pkg::*;

  localparam int BlockRows    = BlockRowsDef;
  localparam int ItemsTarget  = 1350;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 16;
  localparam int PressHold    = 300;
  localparam int WatchLimit   = 3000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  conv_row_panel_pack_addrgen #(
    .BLOCK_ROWS(BlockRows)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // register mirror and packer state
  cfg_t regs_now = '{rows: 13'd1, cols: 13'd1, input_height: 13'd1, stride: 5'd1,
                     dilation: 5'd1, padding: 4'd0, row_pitch: 16'd1};
  logic [PanelW-1:0]      pk_panel = '0;
  logic [DimW-1:0]        pk_col = '0;
  logic [6:0]             pk_row = '0;
  logic signed [BaseW-1:0] pk_base = '0;
  logic                   pk_active = 1'b0;

  in_item_t  feed_q[$];
  out_item_t elems_due_q[$];

  logic calm = 1'b0;
  logic press_go = 1'b0;
  logic press_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  int n_queued = 0, n_starts = 0, n_steps = 0, n_settings = 0;
  int n_checked = 0, n_last = 0, n_zero = 0, n_exh = 0, n_mismatch = 0;

  task automatic predict_pack(in_item_t it);
    out_item_t e;
    longint st, rw, cl, ht, pt, pnl, col, rip, y, dest, rr;
    logic zero;
    logic fin;
    st = regs_now.stride;
    rw = regs_now.rows;
    cl = regs_now.cols;
    ht = regs_now.input_height;
    pt = regs_now.row_pitch;
    e = '0;
    if (it.operation == OpStart) begin
      n_starts++;
      pk_base = BaseW'(st * longint'(it.start_row)
                + longint'(regs_now.dilation) * longint'(it.kernel_row)
                - longint'(regs_now.padding));
      pk_panel = '0;
      pk_col = '0;
      pk_row = '0;
      pk_active = (rw != 0) && (cl != 0);
      return;
    end
    n_steps++;
    if (!pk_active) begin
      e.exhausted = 1'b1;
    end else begin
      pnl = pk_panel;
      col = pk_col;
      rip = pk_row;
      y = longint'(pk_base) + st * (pnl + rip);
      dest = pnl * cl + col * BlockRows + rip;
      zero = (y < 0) || (y >= ht);
      // short last panel, or rows lowered under the current panel
      rr = (rw > pnl) ? ((rw - pnl < BlockRows) ? rw - pnl : BlockRows) : 1;
      e.dest_index = dest[23:0];
      e.source_address = zero ? '0 : 28'(y * pt + col);
      e.zero_fill = zero;
      fin = 1'b0;
      rip++;
      if (rip >= rr) begin
        rip = 0;
        col++;
        if (col >= cl) begin
          col = 0;
          pnl += BlockRows;
          if (pnl >= rw) begin
            fin = 1'b1;
            pnl = 0;
            pk_active = 1'b0;
          end
        end
      end
      e.last = fin;
      pk_panel = PanelW'(pnl);
      pk_col = DimW'(col);
      pk_row = 7'(rip);
    end
    elems_due_q.push_back(e);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) predict_pack(in_item);
      if (!(in_push && in_full)) begin
        if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
          in_item <= feed_q.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  task automatic check_elem(out_item_t got);
    out_item_t want;
    string diff;
    diff = "";
    if (elems_due_q.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("unexpected item: dest=%0d src=%0d zero=%0b last=%0b exh=%0b",
                 got.dest_index, got.source_address, got.zero_fill, got.last, got.exhausted);
      return;
    end
    want = elems_due_q.pop_front();
    n_checked++;
    if (got.last === 1'b1) n_last++;
    if (got.zero_fill === 1'b1) n_zero++;
    if (got.exhausted === 1'b1) n_exh++;
    if (got.dest_index !== want.dest_index) diff = {diff, " dest_index"};
    if (got.source_address !== want.source_address) diff = {diff, " source_address"};
    if (got.zero_fill !== want.zero_fill) diff = {diff, " zero_fill"};
    if (got.last !== want.last) diff = {diff, " last"};
    if (got.exhausted !== want.exhausted) diff = {diff, " exhausted"};
    if (diff != "") begin
      n_mismatch++;
      if (n_mismatch <= 10) begin
        $display("item %0d wrong:%s", n_checked, diff);
        $display("  expected dest=%0d src=%0d zero=%0b last=%0b exh=%0b",
                 want.dest_index, want.source_address, want.zero_fill, want.last,
                 want.exhausted);
        $display("  actual   dest=%0d src=%0d zero=%0b last=%0b exh=%0b",
                 got.dest_index, got.source_address, got.zero_fill, got.last, got.exhausted);
      end
    end
  endtask

  // receiver, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_elem(out_item);
      if (press_go && !press_done) begin
        hold_left = PressHold;
        press_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("no handshake for %0d cycles, %0d items still due", quiet_cycles,
                 elems_due_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegRows:        regs_now.rows = val[12:0];
      RegCols:        regs_now.cols = val[12:0];
      RegInputHeight: regs_now.input_height = val[12:0];
      RegStride:      regs_now.stride = val[4:0];
      RegDilation:    regs_now.dilation = val[4:0];
      RegPadding:     regs_now.padding = val[3:0];
      RegRowPitch:    regs_now.row_pitch = val;
      default: ;
    endcase
  endtask

  // wait until every item went in and every result came out, then let the pipe run dry
  task automatic settle();
    do @(negedge clk); while (feed_q.size() != 0 || in_push || elems_due_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic close_setting();
    cfg_valid <= 1'b0;
    n_settings++;
    @(negedge clk);
  endtask

  task automatic queue_item(op_t op, int unsigned sr, int unsigned kr);
    in_item_t it;
    it.operation = op;
    it.start_row = 12'(sr);
    it.kernel_row = 4'(kr);
    feed_q.push_back(it);
    n_queued++;
  endtask

  task automatic queue_steps(int n);
    repeat (n) queue_item(OpStep, $urandom_range(0, 4095), $urandom_range(0, 15));
  endtask

  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                             int unsigned top);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return top;
    if (roll == 1) return $urandom_range(0, top);
    return $urandom_range(lo, hi);
  endfunction

  task automatic write_random_setting();
    write_reg(RegRows, CfgDataW'(pick_value(1, 20, 8191)));
    write_reg(RegCols, CfgDataW'(pick_value(1, 8, 8191)));
    write_reg(RegInputHeight, CfgDataW'(pick_value(1, 48, 8191)));
    write_reg(RegStride, CfgDataW'(pick_value(1, 3, 31)));
    write_reg(RegDilation, CfgDataW'(pick_value(1, 3, 31)));
    write_reg(RegPadding, CfgDataW'(pick_value(0, 15, 15)));
    write_reg(RegRowPitch, CfgDataW'(pick_value(1, 100, 65535)));
    close_setting();
  endtask

  // mostly whole jobs with random content, some cut short or overrun, some noise
  task automatic fill_jobs(int budget);
    int added;
    longint job_len;
    int n;
    added = 0;
    job_len = longint'(regs_now.rows) * longint'(regs_now.cols);
    while (added < budget) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_item(op_t'($urandom_range(0, 1)), $urandom_range(0, 4095), $urandom_range(0, 15));
        added++;
      end else begin
        queue_item(OpStart, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 15),
                   $urandom_range(0, 15));
        if (job_len == 0 || job_len > 200) begin
          n = $urandom_range(1, 40);
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2: n = int'(job_len) + $urandom_range(1, 3);
            3, 4, 5: n = $urandom_range(1, int'(job_len));
            default: n = int'(job_len);
          endcase
        end
        queue_steps(n);
        added += n + 1;
      end
    end
  endtask

  initial begin
    int ph;
    ph = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: step with no job, a one element job, step after it ends
    queue_item(OpStep, 0, 0);
    queue_item(OpStart, 0, 0);
    queue_item(OpStep, 0, 0);
    queue_item(OpStep, 0, 0);
    settle();

    // short panel, negative and far rows, restart in the middle of a job
    write_reg(RegRows, 3);
    write_reg(RegCols, 2);
    write_reg(RegInputHeight, 2);
    write_reg(RegStride, 2);
    write_reg(RegDilation, 3);
    write_reg(RegPadding, 15);
    write_reg(RegRowPitch, 16'hffff);
    close_setting();
    queue_item(OpStart, 4095, 15);
    queue_item(OpStep, 0, 0);
    queue_item(OpStart, 7, 0);
    queue_steps(3);
    queue_item(OpStart, 0, 5);
    queue_steps(7);
    settle();

    // zero rows opens no job; zero stride and dilation; unused register index
    write_reg(RegRows, 0);
    write_reg(RegStride, 0);
    write_reg(RegDilation, 0);
    write_reg(RegUnused, 16'hffff);
    close_setting();
    queue_item(OpStart, 4095, 15);
    queue_item(OpStep, 4095, 15);
    settle();

    // zero cols opens no job
    write_reg(RegRows, 9);
    write_reg(RegCols, 0);
    close_setting();
    queue_item(OpStart, 0, 0);
    queue_item(OpStep, 0, 0);
    settle();

    // shrink rows and cols while a job is open
    write_reg(RegRows, 20);
    write_reg(RegCols, 3);
    write_reg(RegInputHeight, 8191);
    write_reg(RegPadding, 0);
    close_setting();
    queue_item(OpStart, 9, 2);
    queue_steps(4);
    settle();
    write_reg(RegRows, 2);
    write_reg(RegCols, 1);
    close_setting();
    queue_steps(2);
    settle();

    while (n_queued < ItemsTarget) begin
      if (ph == 4) begin
        write_reg(RegRows, 8191);
        write_reg(RegCols, 8191);
        write_reg(RegInputHeight, 8191);
        write_reg(RegStride, 31);
        write_reg(RegDilation, 31);
        write_reg(RegPadding, 15);
        write_reg(RegRowPitch, 16'hffff);
        close_setting();
      end else begin
        write_random_setting();
      end
      calm = (ph == 2);
      if (ph == 0) press_go = 1'b1;
      fill_jobs((ph == 0) ? 250 : 150);
      settle();
      ph++;
    end
    calm = 1'b0;

    repeat (TailCycles) @(posedge clk);
    $display("sent %0d items (%0d starts, %0d steps) under %0d register settings",
             n_starts + n_steps, n_starts, n_steps, n_settings);
    $display("checked %0d results: %0d job ends, %0d zero filled, %0d with no job",
             n_checked, n_last, n_zero, n_exh);
    if (n_mismatch == 0 && elems_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d wrong results, %0d never arrived", n_mismatch, elems_due_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/crp_pkg.sv
rtl/crp_fifo.sv
rtl/crp_front.sv
rtl/crp_back.sv
rtl/conv_row_panel_pack_addrgen.sv
rtl/crp_checker.sv
tb/tb_conv_row_panel_pack_addrgen.sv
